### rtl/v4m_pkg.sv
package v4m_pkg;

  localparam int WORD_W      = 32;
  localparam int PROD_W      = 2 * WORD_W;
  localparam int NUM_COMP    = 4;
  localparam int NUM_ELEM    = NUM_COMP * NUM_COMP;
  localparam int NUM_PAIRS   = NUM_ELEM / 2;
  localparam int PAIR_IDX_W  = $clog2(NUM_PAIRS);
  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 2 * WORD_W;
  localparam int FRAC_BITS   = 16;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic [CFG_DATA_W-1:0]    pair_t;
  typedef word_t [NUM_COMP-1:0]     vec4_t;
  typedef word_t [NUM_ELEM-1:0]     matrix_t;

  // identity matrix in 16.16, two entries per register
  localparam pair_t COEFF_PAIR_RESET [NUM_PAIRS] = '{
    64'h0000_0000_0001_0000,
    64'h0000_0000_0000_0000,
    64'h0001_0000_0000_0000,
    64'h0000_0000_0000_0000,
    64'h0000_0000_0000_0000,
    64'h0000_0000_0001_0000,
    64'h0000_0000_0000_0000,
    64'h0001_0000_0000_0000
  };

endpackage

### rtl/v4m_pipe.sv
module v4m_pipe
  import v4m_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  matrix_t matrix,
  input  logic    in_valid,
  output logic    in_stall,
  input  vec4_t   in_vec,
  input  logic    in_last,
  output logic    out_valid,
  input  logic    out_stall,
  output vec4_t   out_vec,
  output logic    out_last
);

  logic  v1, v2, v3;
  logic  en1, en2, en3;
  prod_t prod_c [NUM_ELEM];
  prod_t prod   [NUM_ELEM];
  prod_t psum   [2*NUM_COMP];
  prod_t fsum_c [NUM_COMP];
  logic  last1, last2;

  // a stage moves when it is empty or the one after it moves
  assign en3 = !v3 || !out_stall;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign in_stall = !en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
    end
  end

  assign out_valid = v3;

  // stage 1: sixteen independent products, element e = 4*row + col
  for (genvar e = 0; e < NUM_ELEM; e++) begin : g_mul
    assign prod_c[e] = $signed(in_vec[e / NUM_COMP]) * $signed(matrix[e]);
  end

  always_ff @(posedge clk) begin
    if (en1 && in_valid) begin
      for (int e = 0; e < NUM_ELEM; e++) prod[e] <= prod_c[e];
      last1 <= in_last;
    end
  end

  // stage 2: rows 0+1 and rows 2+3 per column, modulo 2^64
  always_ff @(posedge clk) begin
    if (en2 && v1) begin
      for (int c = 0; c < NUM_COMP; c++) begin
        psum[2*c]   <= prod[c] + prod[NUM_COMP + c];
        psum[2*c+1] <= prod[2*NUM_COMP + c] + prod[3*NUM_COMP + c];
      end
      last2 <= last1;
    end
  end

  // stage 3: final add, drop fraction bits, wrap to a word
  for (genvar c = 0; c < NUM_COMP; c++) begin : g_fin
    assign fsum_c[c] = psum[2*c] + psum[2*c+1];
  end

  always_ff @(posedge clk) begin
    if (en3 && v2) begin
      for (int c = 0; c < NUM_COMP; c++) out_vec[c] <= fsum_c[c][FRAC_BITS +: WORD_W];
      out_last <= last2;
    end
  end

endmodule

### rtl/vec4_mat44_fixed_transform.sv
// 4x4 fixed-point transform: row vector (x, y, z, w) times a signed 16.16
// matrix, one result vector per input vector.
// input channel: in_valid / in_stall with vec_x..vec_w and end_of_batch;
// a transaction happens on a clock edge with in_valid high and in_stall low.
// output channel: out_valid / out_stall with out_x..out_w and batch_done.
// config channel: cfg_valid / cfg_ready with cfg_index and cfg_data; index k
// (0..7) loads matrix entries 2k (low word) and 2k+1 (high word), larger
// indexes are dropped. cfg_ready is always high. write only while idle.
// the stages are multiply, pairwise add, final add and shift, each behind
// a register. one vector per cycle is sustained while out_stall is low.
// each column sum is kept modulo 2^64, shifted right by the fraction bits
// and wrapped to 32 bits.
// reset (rst, synchronous) empties the pipeline and loads the identity.
// while out_stall is high the result holds; bubbles in the pipeline close
// up, and in_stall rises only once all three stages hold a vector.
module vec4_mat44_fixed_transform
  import v4m_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic signed [31:0]     vec_x,
  input  logic signed [31:0]     vec_y,
  input  logic signed [31:0]     vec_z,
  input  logic signed [31:0]     vec_w,
  input  logic                   end_of_batch,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic signed [31:0]     out_x,
  output logic signed [31:0]     out_y,
  output logic signed [31:0]     out_z,
  output logic signed [31:0]     out_w,
  output logic                   batch_done,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  pair_t   coeff_pair [NUM_PAIRS];
  matrix_t matrix;
  vec4_t   in_vec;
  vec4_t   out_vec;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_PAIRS; k++) coeff_pair[k] <= COEFF_PAIR_RESET[k];
    end else if (cfg_valid && cfg_ready && (cfg_index < CFG_INDEX_W'(NUM_PAIRS))) begin
      coeff_pair[cfg_index[PAIR_IDX_W-1:0]] <= cfg_data;
    end
  end

  for (genvar k = 0; k < NUM_PAIRS; k++) begin : g_unpack
    assign matrix[2*k]   = coeff_pair[k][WORD_W-1:0];
    assign matrix[2*k+1] = coeff_pair[k][CFG_DATA_W-1:WORD_W];
  end

  assign in_vec[0] = vec_x;
  assign in_vec[1] = vec_y;
  assign in_vec[2] = vec_z;
  assign in_vec[3] = vec_w;

  v4m_pipe u_pipe (
    .clk       (clk),
    .rst       (rst),
    .matrix    (matrix),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_vec    (in_vec),
    .in_last   (end_of_batch),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_vec   (out_vec),
    .out_last  (batch_done)
  );

  assign out_x = out_vec[0];
  assign out_y = out_vec[1];
  assign out_z = out_vec[2];
  assign out_w = out_vec[3];

endmodule

### rtl/v4m_checker.sv
module v4m_props (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result present right after reset");

  // the input side stalls only with a full pipeline behind a stalled output
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output backpressure");

  // with no backpressure an accepted transaction comes out once it has passed every pipeline stage
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) ##1 !out_stall ##1 !out_stall |=> out_valid)
    else $error("result missing after pipeline latency");

endmodule

bind vec4_mat44_fixed_transform v4m_props u_props (.*);
